>>> rtl/kbeb_pkg.sv
package kbeb_pkg;

  typedef enum logic [1:0] {
    OP_KEY  = 2'd0,
    OP_CMD  = 2'd1,
    OP_POLL = 2'd2,
    OP_NONE = 2'd3
  } kbeb_op_e;

  localparam logic [15:0] CMD_CLEAR   = 16'd0;
  localparam logic [15:0] CMD_POP     = 16'd1;
  localparam logic [15:0] CMD_PRESSED = 16'd2;
  localparam logic [15:0] CMD_SET_MSG = 16'd3;

  typedef logic [3:0] kbeb_step_t;

  localparam kbeb_step_t ST_IDLE     = 4'd0;
  localparam kbeb_step_t ST_DECODE   = 4'd1;
  localparam kbeb_step_t ST_PUSH     = 4'd2;
  localparam kbeb_step_t ST_CLEAR    = 4'd3;
  localparam kbeb_step_t ST_SET_MSG  = 4'd4;
  localparam kbeb_step_t ST_POLL     = 4'd5;
  localparam kbeb_step_t ST_POP_RD   = 4'd6;
  localparam kbeb_step_t ST_POP_WB   = 4'd7;
  localparam kbeb_step_t ST_SCAN_RD  = 4'd8;
  localparam kbeb_step_t ST_SCAN_CHK = 4'd9;
  localparam kbeb_step_t ST_EMIT     = 4'd10;

  typedef enum logic [3:0] {
    ACT_WAIT     = 4'd0,
    ACT_DECODE   = 4'd1,
    ACT_PUSH     = 4'd2,
    ACT_CLEAR    = 4'd3,
    ACT_SET_MSG  = 4'd4,
    ACT_POLL     = 4'd5,
    ACT_POP_RD   = 4'd6,
    ACT_POP_WB   = 4'd7,
    ACT_SCAN_RD  = 4'd8,
    ACT_SCAN_CHK = 4'd9,
    ACT_EMIT     = 4'd10
  } kbeb_act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_NO_ACCEPT = 3'd1,
    COND_DISPATCH  = 3'd2,
    COND_SCAN_DONE = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } kbeb_cond_e;

  // one control word: action, jump condition, target when taken, next otherwise
  typedef struct packed {
    kbeb_act_e  act;
    kbeb_cond_e cond;
    kbeb_step_t jmp;
    kbeb_step_t nxt;
  } kbeb_uword_t;

  // status from the datapath that steers the sequencer
  typedef struct packed {
    logic       accept;
    logic       out_busy;
    logic       scan_done;
    kbeb_step_t dispatch;
  } kbeb_flags_t;

  function automatic kbeb_uword_t ucode_rom(input kbeb_step_t step);
    kbeb_uword_t w;
    case (step)
      ST_IDLE:     w = '{ACT_WAIT,     COND_NO_ACCEPT, ST_IDLE,    ST_DECODE};
      ST_DECODE:   w = '{ACT_DECODE,   COND_DISPATCH,  ST_EMIT,    ST_EMIT};
      ST_PUSH:     w = '{ACT_PUSH,     COND_ALWAYS,    ST_EMIT,    ST_EMIT};
      ST_CLEAR:    w = '{ACT_CLEAR,    COND_ALWAYS,    ST_EMIT,    ST_EMIT};
      ST_SET_MSG:  w = '{ACT_SET_MSG,  COND_ALWAYS,    ST_EMIT,    ST_EMIT};
      ST_POLL:     w = '{ACT_POLL,     COND_ALWAYS,    ST_EMIT,    ST_EMIT};
      ST_POP_RD:   w = '{ACT_POP_RD,   COND_ALWAYS,    ST_POP_WB,  ST_POP_WB};
      ST_POP_WB:   w = '{ACT_POP_WB,   COND_ALWAYS,    ST_EMIT,    ST_EMIT};
      ST_SCAN_RD:  w = '{ACT_SCAN_RD,  COND_ALWAYS,    ST_SCAN_CHK, ST_SCAN_CHK};
      ST_SCAN_CHK: w = '{ACT_SCAN_CHK, COND_SCAN_DONE, ST_EMIT,    ST_SCAN_RD};
      ST_EMIT:     w = '{ACT_EMIT,     COND_OUT_BUSY,  ST_EMIT,    ST_IDLE};
      default:     w = '{ACT_WAIT,     COND_ALWAYS,    ST_IDLE,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/kbeb_in_if.sv
interface kbeb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        key_down;
  logic [7:0]  scancode;
  logic [15:0] command_code;
  logic [15:0] command_arg;

  modport source (
    output valid, op, key_down, scancode, command_code, command_arg,
    input  ready
  );
  modport sink (
    input  valid, op, key_down, scancode, command_code, command_arg,
    output ready
  );
endinterface

>>> rtl/kbeb_out_if.sv
interface kbeb_out_if;
  logic        valid;
  logic        ready;
  logic        c_write;
  logic [8:0]  c_value;
  logic        irq;
  logic [15:0] irq_message;

  modport source (
    output valid, c_write, c_value, irq, irq_message,
    input  ready
  );
  modport sink (
    input  valid, c_write, c_value, irq, irq_message,
    output ready
  );
endinterface

>>> rtl/keyboard_event_buffer_top.sv
// Keyboard event buffer. Takes one item at a time on in_i and returns exactly one result
// item on out_o for each. Every item has a decode step and an emit step. Key events,
// clear, set-message and polls add one action step, a pop a read and a write-back step
// (none on an empty buffer). Unknown command codes and the unused op add none. An
// is-pressed check scans entries newest-first until a match, at most BUFFER_DEPTH and
// none on an empty buffer. The scan cost comes from the single read port of the event
// store and its registered read data: each entry needs one read step and one compare step
// of the microprogram. A new item is taken in the cycle after its predecessor's result is
// handed to the output register, even if that result is still waiting to be taken.
// Entries of the store are not cleared at reset; only entries counted as valid are read.
module keyboard_event_buffer_top #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kbeb_in_if.sink    in_i,
  kbeb_out_if.source out_o
);

  localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [IW:0]   DepthW = (IW + 1)'(BUFFER_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(BUFFER_DEPTH);
  localparam logic [IW-1:0] LastIdx = IW'(BUFFER_DEPTH - 1);

  kbeb_pkg::kbeb_act_e   act;
  kbeb_pkg::kbeb_flags_t flags;

  logic        accept;
  logic        out_free;

  // latched item
  logic [1:0]  op_q;
  logic        down_q;
  logic [7:0]  scan_q;
  logic [15:0] cmd_q;
  logic [15:0] arg_q;

  // buffer state
  logic [8:0]    store_q [BUFFER_DEPTH];
  logic [8:0]    rdata_q;
  logic [IW-1:0] newest_q;
  logic [CW-1:0] count_q;
  logic [15:0]   msg_q;
  logic          pend_q;
  logic [CW-1:0] idx_q;

  // result under construction
  logic        res_cw_q;
  logic [8:0]  res_cv_q;
  logic        res_irq_q;
  logic [15:0] res_msg_q;

  // output register
  logic        ov_q;
  logic        o_cw_q;
  logic [8:0]  o_cv_q;
  logic        o_irq_q;
  logic [15:0] o_msg_q;

  logic [IW-1:0] back;
  logic [IW:0]   back_sum;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] push_addr;
  logic          match;
  logic [CW-1:0] idx_inc;
  logic          is_cmd;

  assign in_i.ready = (act == kbeb_pkg::ACT_WAIT);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !ov_q || out_o.ready;

  assign is_cmd = (op_q == kbeb_pkg::OP_CMD);
  assign match  = (rdata_q[7:0] == arg_q[7:0]);
  assign idx_inc = idx_q + 1'b1;

  // slot that lies "back" places older than the newest one
  always_comb begin
    back = (act == kbeb_pkg::ACT_POP_RD) ? IW'(count_q - 1'b1) : IW'(idx_q);
    back_sum = {1'b0, newest_q} + DepthW - {1'b0, back};
    if (back_sum >= DepthW) begin
      back_sum = back_sum - DepthW;
    end
    rd_addr   = back_sum[IW-1:0];
    push_addr = (newest_q == LastIdx) ? '0 : newest_q + 1'b1;
  end

  always_comb begin
    flags.accept    = accept;
    flags.out_busy  = !out_free;
    flags.scan_done = match || (idx_inc == count_q);
    case (op_q)
      kbeb_pkg::OP_KEY:  flags.dispatch = kbeb_pkg::ST_PUSH;
      kbeb_pkg::OP_POLL: flags.dispatch = kbeb_pkg::ST_POLL;
      kbeb_pkg::OP_CMD: begin
        case (cmd_q)
          kbeb_pkg::CMD_CLEAR:   flags.dispatch = kbeb_pkg::ST_CLEAR;
          kbeb_pkg::CMD_POP:     flags.dispatch = (count_q != '0) ? kbeb_pkg::ST_POP_RD
                                                                  : kbeb_pkg::ST_EMIT;
          kbeb_pkg::CMD_PRESSED: flags.dispatch = (count_q != '0) ? kbeb_pkg::ST_SCAN_RD
                                                                  : kbeb_pkg::ST_EMIT;
          kbeb_pkg::CMD_SET_MSG: flags.dispatch = kbeb_pkg::ST_SET_MSG;
          default:               flags.dispatch = kbeb_pkg::ST_EMIT;
        endcase
      end
      default: flags.dispatch = kbeb_pkg::ST_EMIT;
    endcase
  end

  kbeb_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_i.op;
      down_q <= in_i.key_down;
      scan_q <= in_i.scancode;
      cmd_q  <= in_i.command_code;
      arg_q  <= in_i.command_arg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act == kbeb_pkg::ACT_PUSH) begin
      store_q[push_addr] <= {down_q, scan_q};
    end
    if (act == kbeb_pkg::ACT_POP_RD || act == kbeb_pkg::ACT_SCAN_RD) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      count_q  <= '0;
      msg_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      case (act)
        kbeb_pkg::ACT_PUSH: begin
          newest_q <= push_addr;
          if (count_q != DepthC) begin
            count_q <= count_q + 1'b1;
          end
          pend_q <= 1'b1;
        end
        kbeb_pkg::ACT_CLEAR:   count_q <= '0;
        kbeb_pkg::ACT_SET_MSG: msg_q <= arg_q;
        kbeb_pkg::ACT_POLL: begin
          if (pend_q && msg_q != '0) begin
            pend_q <= 1'b0;
          end
        end
        kbeb_pkg::ACT_POP_WB:  count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (act)
      kbeb_pkg::ACT_DECODE: begin
        res_cw_q  <= is_cmd && (cmd_q == kbeb_pkg::CMD_POP || cmd_q == kbeb_pkg::CMD_PRESSED);
        res_cv_q  <= '0;
        res_irq_q <= 1'b0;
        res_msg_q <= '0;
        idx_q     <= '0;
      end
      kbeb_pkg::ACT_POLL: begin
        if (pend_q && msg_q != '0) begin
          res_irq_q <= 1'b1;
          res_msg_q <= msg_q;
        end
      end
      kbeb_pkg::ACT_POP_WB: res_cv_q <= rdata_q;
      kbeb_pkg::ACT_SCAN_CHK: begin
        if (match) begin
          res_cv_q <= {8'd0, rdata_q[8]};
        end
        idx_q <= idx_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (act == kbeb_pkg::ACT_EMIT && out_free) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act == kbeb_pkg::ACT_EMIT && out_free) begin
      o_cw_q  <= res_cw_q;
      o_cv_q  <= res_cv_q;
      o_irq_q <= res_irq_q;
      o_msg_q <= res_msg_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.c_write     = o_cw_q;
  assign out_o.c_value     = o_cv_q;
  assign out_o.irq         = o_irq_q;
  assign out_o.irq_message = o_msg_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> act == kbeb_pkg::ACT_DECODE)
    else $error("accepted item not decoded next");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act == kbeb_pkg::ACT_EMIT && out_free) |=> ov_q)
    else $error("emit did not load output register");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act == kbeb_pkg::ACT_SCAN_RD |-> idx_q < count_q)
    else $error("scan index past valid entries");

endmodule

>>> rtl/kbeb_seq.sv
module kbeb_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kbeb_pkg::kbeb_flags_t flags_i,
  output kbeb_pkg::kbeb_act_e act_o
);

  kbeb_pkg::kbeb_step_t  pc_q, pc_d;
  kbeb_pkg::kbeb_uword_t uw;
  logic                  taken;

  assign uw    = kbeb_pkg::ucode_rom(pc_q);
  assign act_o = uw.act;

  always_comb begin
    case (uw.cond)
      kbeb_pkg::COND_ALWAYS:    taken = 1'b1;
      kbeb_pkg::COND_NO_ACCEPT: taken = !flags_i.accept;
      kbeb_pkg::COND_DISPATCH:  taken = 1'b1;
      kbeb_pkg::COND_SCAN_DONE: taken = flags_i.scan_done;
      kbeb_pkg::COND_OUT_BUSY:  taken = flags_i.out_busy;
      default:                  taken = 1'b1;
    endcase
    if (!taken) begin
      pc_d = uw.nxt;
    end else if (uw.cond == kbeb_pkg::COND_DISPATCH) begin
      pc_d = flags_i.dispatch;
    end else begin
      pc_d = uw.jmp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= kbeb_pkg::ST_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
